### rtl/csr_sparse_matrix_vector_mac_assert.svh
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_mac_assert.svh
// Assertion macros for the CSR SpMV MAC block.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_VECTOR_MAC_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MAC_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define CSVM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define CSVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CSVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/csvm_pkg.sv
// ----------------------------------------------------------------------------
// csvm_pkg
// Shared types for the CSR sparse matrix-vector MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csvm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_BEGIN   = 2'd1,
    CMD_NONZERO = 2'd2,
    CMD_END     = 2'd3
  } cmd_e;

  // Beat leaving the input stage toward the MAC datapath.
  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic signed [31:0] value;
    logic signed [31:0] xval;
  } csvm_beat_t;

endpackage

### rtl/csvm_xstore.sv
// ----------------------------------------------------------------------------
// csvm_xstore
// Dense x vector store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvm_xstore #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [31:0]          wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  input  logic                 rvalid_addr_i,
  output logic signed [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic        in_range_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q    <= mem[raddr_i];
      in_range_q <= rvalid_addr_i;
    end
  end

  // out-of-range column reads as zero
  assign rdata_o = in_range_q ? rdata_q : 32'sd0;

endmodule

### rtl/csvm_mac.sv
// ----------------------------------------------------------------------------
// csvm_mac
// Multiply stage, saturating Q32.32 accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "csr_sparse_matrix_vector_mac_assert.svh"

module csvm_mac
  import csvm_pkg::*;
#(
  parameter int unsigned ROW_COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csvm_beat_t         s1_beat_i,
  output logic               s1_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        row_number_o,
  output logic signed [63:0] row_sum_o,
  output logic               overflow_o
);

  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  // multiply stage
  logic               s2_valid_q;
  cmd_e               s2_cmd_q;
  logic signed [63:0] s2_term_q;
  logic signed [63:0] term_d;
  logic               s2_go;
  logic               s2_ready;
  logic               out_free;

  // accumulate stage
  logic [63:0]               acc_q, acc_d;
  logic                      sat_q, sat_d;
  logic [ROW_COUNT_BITS-1:0] row_cnt_q, row_cnt_d;
  logic [63:0]               sum;
  logic                      add_ovf;
  logic [15:0]               cnt_ext;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_row_q;
  logic [63:0]        out_sum_q;
  logic               out_ovf_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && ((s2_cmd_q != CMD_END) || out_free);
  assign s2_ready   = !s2_valid_q || s2_go;
  assign s1_ready_o = s2_ready;

  always_comb begin
    if (s1_beat_i.cmd == CMD_BEGIN) begin
      term_d = {{16{s1_beat_i.value[31]}}, s1_beat_i.value, 16'b0};
    end else begin
      term_d = s1_beat_i.value * s1_beat_i.xval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_beat_i.valid) begin
      s2_cmd_q  <= s1_beat_i.cmd;
      s2_term_q <= term_d;
    end
  end

  assign sum     = acc_q + s2_term_q;
  assign add_ovf = (acc_q[63] == s2_term_q[63]) && (sum[63] != acc_q[63]);
  assign cnt_ext = 16'(row_cnt_q);

  always_comb begin
    acc_d       = acc_q;
    sat_d       = sat_q;
    row_cnt_d   = row_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (s2_go) begin
      case (s2_cmd_q)
        CMD_BEGIN: begin
          acc_d = s2_term_q;
          sat_d = 1'b0;
        end
        CMD_NONZERO: begin
          if (add_ovf) begin
            acc_d = acc_q[63] ? SAT_MIN : SAT_MAX;
            sat_d = 1'b1;
          end else begin
            acc_d = sum;
          end
        end
        CMD_END: begin
          row_cnt_d   = row_cnt_q + ROW_COUNT_BITS'(1);
          out_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      sat_q       <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && (s2_cmd_q == CMD_END)) begin
      out_row_q <= cnt_ext;
      out_sum_q <= acc_q;
      out_ovf_q <= sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_row_q;
  assign row_sum_o    = out_sum_q;
  assign overflow_o   = out_ovf_q;

  `CSVM_ASSERT(a_end_loads_result, clk_i, rst_ni,
    (s2_go && (s2_cmd_q == CMD_END)) |=> out_valid_q, "end-row beat produced no result")
  `CSVM_ASSERT(a_row_count_step, clk_i, rst_ni,
    (s2_go && (s2_cmd_q == CMD_END)) |=> (row_cnt_q == $past(row_cnt_q) + ROW_COUNT_BITS'(1)),
    "row counter did not advance by one")
  `CSVM_ASSERT(a_begin_clears_sat, clk_i, rst_ni,
    (s2_go && (s2_cmd_q == CMD_BEGIN)) |=> !sat_q, "begin row left saturation flag set")
  `CSVM_ASSERT_NEVER(a_end_over_full, clk_i, rst_ni,
    s2_go && (s2_cmd_q == CMD_END) && out_valid_q && !out_ready_i,
    "end-row beat overwrote a pending result")

endmodule

### rtl/csr_sparse_matrix_vector_mac.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_mac
// CSR sparse matrix-vector multiply-accumulate, y += A*x, Q16.16 operands,
// saturating Q32.32 row sums.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | command, column_index, operand_value
//  out     | output    | out_valid_o/out_ready_i | row_number, row_sum, overflow
//
//  One beat per cycle unless an end-row beat waits on a pending result; every
//  command takes one slot in a three-stage pipe (input/x-read register, 32x32
//  product register, accumulator/result register), the last holding results.
//  Reset clears control, accumulator, flag and row counter at once; the x
//  store has no clearing pass and is undefined until loaded.
//  A waiting result stalls only an end-row beat and the beats queued behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_mac
  import csvm_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH   = 1024,
  parameter int unsigned ROW_COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [9:0]         column_index_i,
  input  logic signed [31:0] operand_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        row_number_o,
  output logic signed [63:0] row_sum_o,
  output logic               overflow_o
);

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic               in_fire;
  logic [31:0]        col_ext;
  logic [AW-1:0]      x_addr;
  logic               col_in_range;
  cmd_e               in_cmd;

  // input stage; x read data comes out of the store's read register
  logic               s1_valid_q;
  cmd_e               s1_cmd_q;
  logic signed [31:0] s1_value_q;
  logic signed [31:0] s1_xval;
  logic               s1_ready;
  csvm_beat_t         s1_beat;

  assign in_cmd       = cmd_e'(command_i);
  assign col_ext      = 32'(column_index_i);
  assign x_addr       = col_ext[AW-1:0];
  assign col_in_range = col_ext < VECTOR_DEPTH;

  assign in_ready_o = !s1_valid_q || s1_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= in_cmd;
      s1_value_q <= operand_value_i;
    end
  end

  // loads write at accept; a later nonzero beat reads after that edge
  csvm_xstore #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_xstore (
    .clk_i         (clk_i),
    .we_i          (in_fire && (in_cmd == CMD_LOAD) && col_in_range),
    .waddr_i       (x_addr),
    .wdata_i       (operand_value_i),
    .re_i          (in_fire),
    .raddr_i       (x_addr),
    .rvalid_addr_i (col_in_range),
    .rdata_o       (s1_xval)
  );

  assign s1_beat.valid = s1_valid_q;
  assign s1_beat.cmd   = s1_cmd_q;
  assign s1_beat.value = s1_value_q;
  assign s1_beat.xval  = s1_xval;

  csvm_mac #(
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_beat_i    (s1_beat),
    .s1_ready_o   (s1_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_number_o (row_number_o),
    .row_sum_o    (row_sum_o),
    .overflow_o   (overflow_o)
  );

endmodule
